[hdl/hcb_pkg.sv]
`default_nettype none
package hcb_pkg;

    // Field widths of one result transaction.
    localparam int SYMBOL_W = 5;
    localparam int LENGTH_W = 5;
    localparam int BITS_W   = 28;

    // Byte codes and the symbols they map to.
    localparam logic [7:0] BYTE_LOWER_A = 8'd97;
    localparam logic [7:0] BYTE_LOWER_Z = 8'd122;
    localparam logic [7:0] BYTE_SPACE   = 8'd32;
    localparam logic [7:0] BYTE_NEWLINE = 8'd10;
    localparam logic [4:0] SYM_SPACE    = 5'd26;
    localparam logic [4:0] SYM_NEWLINE  = 5'd27;

    // Input kind codes.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Sequencer states.
    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_INIT      = 8'b0000_0010,
        S_SCAN      = 8'b0000_0100,
        S_LINK_A    = 8'b0000_1000,
        S_LINK_B    = 8'b0001_0000,
        S_WALK_RD   = 8'b0010_0000,
        S_WALK_WAIT = 8'b0100_0000,
        S_EMIT      = 8'b1000_0000
    } t_state;

    // Control from the sequencer to the counter bank.
    typedef struct packed {
        logic inc;
        logic clr;
    } t_cnt_ctrl;

    // Map a byte to a symbol; bit 5 flags a known character.
    function automatic logic [5:0] map_byte(input logic [7:0] b);
        logic [7:0] d;
        d = b - BYTE_LOWER_A;
        if (b >= BYTE_LOWER_A && b <= BYTE_LOWER_Z) begin
            return {1'b1, d[4:0]};
        end else if (b == BYTE_SPACE) begin
            return {1'b1, SYM_SPACE};
        end else if (b == BYTE_NEWLINE) begin
            return {1'b1, SYM_NEWLINE};
        end
        return 6'd0;
    endfunction

endpackage
`default_nettype wire

[hdl/hcb_ram.sv]
`default_nettype none
module hcb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/hcb_counts.sv]
`default_nettype none
module hcb_counts #(
    parameter int NUM_SYMBOLS = 29,
    parameter int COUNT_WIDTH = 20,
    parameter int SYM_W       = $clog2(NUM_SYMBOLS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire hcb_pkg::t_cnt_ctrl    i_ctrl,
    input  wire logic [SYM_W-1:0]      i_idx,
    output logic      [COUNT_WIDTH-1:0] o_count
);
    import hcb_pkg::*;

    logic [COUNT_WIDTH-1:0] r_count [NUM_SYMBOLS];

    // One shared address serves both the increment and the tree load.
    assign o_count = r_count[i_idx];

    // Saturating counters, cleared after each code table is sent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_ctrl.inc && o_count != '1) begin
            r_count[i_idx] <= o_count + 1'b1;
        end
    end
endmodule
`default_nettype wire

[hdl/huffman_code_builder_core.sv]
`default_nettype none
// Channel | Direction | Handshake                | Payload
// input   | in        | i_in_valid / o_in_stall  | i_kind, i_char_byte
// output  | out       | o_out_valid / i_out_stall | o_symbol, o_code_length, o_code_bits, o_last
//
// Character transactions may follow one another back to back while the block is idle.
// An end transaction loads NUM_SYMBOLS leaves (one per cycle), then runs
// NUM_SYMBOLS-1 merges; merge k makes two scans over the NUM_SYMBOLS+k slots built so far
// plus two link writes, and both scans go through the single read port of the weight memory.
// Each symbol then walks up through WALK_RD and WALK_WAIT per tree level, forms its result
// in WALK_RD at the root and holds it in EMIT until it is taken.
// Reset is synchronous and clears counts, live flags and the sequencer.
// The input is stalled for the whole build; a stalled result holds its payload.
module huffman_code_builder_core #(
    parameter int NUM_SYMBOLS  = 29,
    parameter int COUNT_WIDTH  = 20,
    parameter int MAX_CODE_LEN = 28
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_char_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [hcb_pkg::SYMBOL_W-1:0] o_symbol,
    output logic [hcb_pkg::LENGTH_W-1:0] o_code_length,
    output logic [hcb_pkg::BITS_W-1:0]   o_code_bits,
    output logic             o_last
);
    import hcb_pkg::*;

    localparam int NODE_SLOTS = 2 * NUM_SYMBOLS - 1;
    localparam int SLOT_W     = $clog2(NODE_SLOTS);
    localparam int SYM_W      = $clog2(NUM_SYMBOLS);
    localparam int DEPTH_W    = $clog2(NODE_SLOTS + 1);
    localparam int WT_W       = COUNT_WIDTH + SYM_W + 1;
    localparam int LEN_W      = $clog2(MAX_CODE_LEN + 1);
    localparam int M          = MAX_CODE_LEN;
    localparam logic [SLOT_W-1:0] ROOT      = SLOT_W'(NODE_SLOTS - 1);
    localparam logic [SLOT_W-1:0] LAST_LEAF = SLOT_W'(NUM_SYMBOLS - 1);

    t_state                  r_state, n_state;
    logic [SLOT_W-1:0]       r_k, n_k;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic                    r_rd_v, n_rd_v;
    logic [SLOT_W-1:0]       r_rd_k, n_rd_k;
    logic                    r_best_v, n_best_v;
    logic [SLOT_W-1:0]       r_best, n_best;
    logic [WT_W-1:0]         r_best_w, n_best_w;
    logic                    r_pick, n_pick;
    logic [SLOT_W-1:0]       r_a, n_a;
    logic [WT_W-1:0]         r_wa, n_wa;
    logic [SYM_W-1:0]        r_sym, n_sym;
    logic [SLOT_W-1:0]       r_node, n_node;
    logic [DEPTH_W-1:0]      r_depth, n_depth;
    logic [M-1:0]            r_acc, n_acc;
    logic [NODE_SLOTS-1:0]   r_live, n_live;
    logic [SYMBOL_W-1:0]     n_symbol;
    logic [LENGTH_W-1:0]     n_code_length;
    logic [BITS_W-1:0]       n_code_bits;
    logic                    n_last;

    logic                    in_acc;
    logic [5:0]              mapped;
    logic                    sym_ok;
    logic [SYM_W-1:0]        cnt_idx;
    logic [COUNT_WIDTH-1:0]  cnt_val;
    t_cnt_ctrl               cnt_ctrl;
    logic                    wt_we;
    logic [SLOT_W-1:0]       wt_waddr;
    logic [WT_W-1:0]         wt_wdata;
    logic [WT_W-1:0]         wt_rdata;
    logic                    ln_we;
    logic [SLOT_W-1:0]       ln_waddr;
    logic [SLOT_W:0]         ln_wdata;
    logic [SLOT_W:0]         ln_rdata;
    logic                    cand;
    logic [LEN_W-1:0]        len;
    logic [LEN_W-1:0]        shamt;
    logic [M-1:0]            bits;
    logic [M:0]              acc_ext;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_acc      = i_in_valid && !o_in_stall;

    // Character mapping; the end-of-file slot and beyond are not counted.
    assign mapped  = map_byte(i_char_byte);
    assign sym_ok  = mapped[5] && (32'(mapped[4:0]) < NUM_SYMBOLS - 1);
    assign cnt_idx = (r_state == S_INIT) ? r_k[SYM_W-1:0] : SYM_W'(mapped[4:0]);

    assign cnt_ctrl.inc = in_acc && (i_kind == KIND_CHAR) && sym_ok;
    assign cnt_ctrl.clr = (r_state == S_EMIT) && !i_out_stall && o_last;

    hcb_counts #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cnt_ctrl),
        .i_idx   (cnt_idx),
        .o_count (cnt_val)
    );

    // Node weights: leaves are loaded in INIT, merged nodes in LINK_A.
    assign wt_we    = (r_state == S_INIT) || (r_state == S_LINK_A);
    assign wt_waddr = (r_state == S_INIT) ? r_k : r_slot;
    assign wt_wdata = (r_state == S_INIT)
                    ? ((r_k == LAST_LEAF) ? WT_W'(1) : WT_W'(cnt_val))
                    : r_wa + r_best_w;

    hcb_ram #(
        .WIDTH (WT_W),
        .DEPTH (NODE_SLOTS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (r_k),
        .o_rdata (wt_rdata)
    );

    // Parent links with the branch side in bit 0.
    assign ln_we    = (r_state == S_LINK_A) || (r_state == S_LINK_B);
    assign ln_waddr = (r_state == S_LINK_A) ? r_a : r_best;
    assign ln_wdata = {r_slot, (r_state == S_LINK_B)};

    hcb_ram #(
        .WIDTH (SLOT_W + 1),
        .DEPTH (NODE_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (ln_waddr),
        .i_wdata (ln_wdata),
        .i_raddr (r_node),
        .o_rdata (ln_rdata)
    );

    // Shared compare: strict less keeps the lower slot on ties.
    assign cand = r_rd_v && r_live[r_rd_k] && (!r_best_v || wt_rdata < r_best_w);

    // Code length clamp and alignment of the root branch to the top used bit.
    always_comb begin
        if (32'(r_depth) > M) begin
            len = LEN_W'(M);
        end else begin
            len = LEN_W'(r_depth);
        end
        shamt = LEN_W'(M) - len;
        bits  = r_acc >> shamt;
    end

    assign acc_ext = {ln_rdata[0], r_acc};

    // Sequencer next state.
    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_slot        = r_slot;
        n_rd_v        = 1'b0;
        n_rd_k        = r_rd_k;
        n_best_v      = r_best_v;
        n_best        = r_best;
        n_best_w      = r_best_w;
        n_pick        = r_pick;
        n_a           = r_a;
        n_wa          = r_wa;
        n_sym         = r_sym;
        n_node        = r_node;
        n_depth       = r_depth;
        n_acc         = r_acc;
        n_live        = r_live;
        n_symbol      = o_symbol;
        n_code_length = o_code_length;
        n_code_bits   = o_code_bits;
        n_last        = o_last;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_kind == KIND_END) begin
                    n_live  = '0;
                    n_k     = '0;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_live[r_k] = 1'b1;
                if (r_k == LAST_LEAF) begin
                    n_slot   = SLOT_W'(NUM_SYMBOLS);
                    n_k      = '0;
                    n_pick   = 1'b0;
                    n_best_v = 1'b0;
                    n_state  = S_SCAN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SCAN: begin
                if (cand) begin
                    n_best_v = 1'b1;
                    n_best   = r_rd_k;
                    n_best_w = wt_rdata;
                end
                if (r_k != r_slot) begin
                    n_rd_v = 1'b1;
                    n_rd_k = r_k;
                    n_k    = r_k + 1'b1;
                end else begin
                    n_live[n_best] = 1'b0;
                    n_best_v       = 1'b0;
                    n_k            = '0;
                    if (!r_pick) begin
                        n_a    = n_best;
                        n_wa   = n_best_w;
                        n_pick = 1'b1;
                    end else begin
                        n_state = S_LINK_A;
                    end
                end
            end
            S_LINK_A: begin
                n_live[r_slot] = 1'b1;
                n_state        = S_LINK_B;
            end
            S_LINK_B: begin
                if (r_slot == ROOT) begin
                    n_sym   = '0;
                    n_node  = '0;
                    n_depth = '0;
                    n_acc   = '0;
                    n_state = S_WALK_RD;
                end else begin
                    n_slot   = r_slot + 1'b1;
                    n_k      = '0;
                    n_pick   = 1'b0;
                    n_best_v = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_WALK_RD: begin
                if (r_node == ROOT || 32'(r_depth) == NODE_SLOTS) begin
                    n_symbol      = SYMBOL_W'(r_sym);
                    n_code_length = LENGTH_W'(len);
                    n_code_bits   = BITS_W'(bits);
                    n_last        = (r_sym == SYM_W'(NUM_SYMBOLS - 1));
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT: begin
                // Branches enter at the top; leaf-level ones fall off when too long.
                n_acc   = acc_ext[M:1];
                n_node  = ln_rdata[SLOT_W:1];
                n_depth = r_depth + 1'b1;
                n_state = S_WALK_RD;
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_sym   = r_sym + 1'b1;
                        n_node  = SLOT_W'(r_sym) + 1'b1;
                        n_depth = '0;
                        n_acc   = '0;
                        n_state = S_WALK_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_rd_v  <= n_rd_v;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_k           <= n_k;
        r_slot        <= n_slot;
        r_rd_k        <= n_rd_k;
        r_best_v      <= n_best_v;
        r_best        <= n_best;
        r_best_w      <= n_best_w;
        r_pick        <= n_pick;
        r_a           <= n_a;
        r_wa          <= n_wa;
        r_sym         <= n_sym;
        r_node        <= n_node;
        r_depth       <= n_depth;
        r_acc         <= n_acc;
        o_symbol      <= n_symbol;
        o_code_length <= n_code_length;
        o_code_bits   <= n_code_bits;
        o_last        <= n_last;
    end
endmodule
`default_nettype wire

[hdl/hcb_checker.sv]
`default_nettype none
module hcb_checker #(
    parameter int NUM_SYMBOLS = 29
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_kind,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [4:0]  o_symbol,
    input wire logic [27:0] o_code_bits,
    input wire logic        o_last
);
    import hcb_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_symbol)
            && $stable(o_code_bits) && $stable(o_last)))
        else $error("stalled result changed");

    // No input is taken while results are being sent.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during result transmission");

    // The final result carries the end-of-file symbol.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_symbol == 5'(NUM_SYMBOLS - 1)))
        else $error("last flag on wrong symbol");

    // A character transaction leaves the block ready for the next one.
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind == KIND_CHAR) |=> !o_in_stall)
        else $error("character transaction stalled input");

    // Each code needs a tree walk, so results never come back to back.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> !o_out_valid)
        else $error("result followed without a walk");
endmodule

bind huffman_code_builder_core hcb_checker #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
) u_hcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_kind      (i_kind),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_symbol    (o_symbol),
    .o_code_bits (o_code_bits),
    .o_last      (o_last)
);
`default_nettype wire
